@@ rtl/jdb_pkg.sv @@
// Package for the twenty-step divstep jump block.
// Holds the beat types, default parameter values and packing constants.
// No dependencies.
`timescale 1ns / 1ps

package jdb_pkg;

  localparam int STEPS_PER_JUMP = 20;
  localparam int DELTA_BITS = 16;
  localparam int DELTA_FIELD_W = 16;

  localparam int WORD_W = 64;
  localparam int COEF_W = 22;
  localparam int PROD_W = 86;
  localparam int SCALE_SHIFT = 20;

  localparam logic [WORD_W-1:0] HALF_ROUND = 64'h0000_0000_0010_0000;

  typedef struct packed {
    logic signed [15:0] delta_in;
    logic signed [63:0] f_in;
    logic signed [63:0] g_in;
    logic signed [63:0] uu_in;
    logic signed [63:0] vv_in;
    logic signed [63:0] rr_in;
    logic signed [63:0] ss_in;
  } jdb_in_t;

  typedef struct packed {
    logic signed [15:0] delta_out;
    logic signed [63:0] f_out;
    logic signed [63:0] g_out;
    logic signed [63:0] uu_out;
    logic signed [63:0] vv_out;
    logic signed [63:0] rr_out;
    logic signed [63:0] ss_out;
  } jdb_out_t;

endpackage

@@ rtl/jdb_step_cell.sv @@
// One divstep cell of the jump chain: a single step on the packed words.
// The beat payload rides along unchanged. Depends on jdb_pkg.
`timescale 1ns / 1ps

module jdb_step_cell #(
  parameter int DELTA_BITS = jdb_pkg::DELTA_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  input  logic [jdb_pkg::WORD_W-1:0]   up_fw,
  input  logic [jdb_pkg::WORD_W-1:0]   up_gw,
  input  logic signed [DELTA_BITS-1:0] up_delta,
  input  jdb_pkg::jdb_in_t             up_data,
  output logic                         valid,
  output logic [jdb_pkg::WORD_W-1:0]   fw,
  output logic [jdb_pkg::WORD_W-1:0]   gw,
  output logic signed [DELTA_BITS-1:0] delta,
  output jdb_pkg::jdb_in_t             data
);

  localparam logic signed [DELTA_BITS-1:0] DELTA_MAX =
    DELTA_BITS'({1'b0, {(DELTA_BITS-1){1'b1}}});
  localparam logic signed [DELTA_BITS-1:0] DELTA_TWO = DELTA_BITS'(2);
  localparam logic signed [DELTA_BITS-1:0] DELTA_LIM = DELTA_MAX - DELTA_TWO;
  localparam logic signed [DELTA_BITS-1:0] DELTA_ZERO = '0;

  logic                         g0;
  logic                         swap;
  logic [jdb_pkg::WORD_W-1:0]   gsum;
  logic [jdb_pkg::WORD_W-1:0]   fw_next;
  logic [jdb_pkg::WORD_W-1:0]   gw_next;
  logic signed [DELTA_BITS-1:0] dsw;
  logic signed [DELTA_BITS-1:0] delta_next;

  // When the step swaps, g0 is set, the new f is the old g and the new g is g - f shifted right by one.
  always_comb begin
    g0 = up_gw[0];
    swap = g0 && (up_delta > DELTA_ZERO);
    if (!g0) begin
      gsum = up_gw;
    end else if (swap) begin
      gsum = up_gw - up_fw;
    end else begin
      gsum = up_gw + up_fw;
    end
    fw_next = swap ? up_gw : up_fw;
    gw_next = {gsum[jdb_pkg::WORD_W-1], gsum[jdb_pkg::WORD_W-1:1]};
    dsw = swap ? -up_delta : up_delta;
    delta_next = (dsw > DELTA_LIM) ? DELTA_MAX : dsw + DELTA_TWO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    fw <= fw_next;
    gw <= gw_next;
    delta <= delta_next;
    data <= up_data;
  end

endmodule

@@ rtl/jdb_combine.sv @@
// Matrix extraction and product pipeline that follows the divstep chain.
// Four stages: extract, partial products, full products, sums. Depends on jdb_pkg.
`timescale 1ns / 1ps

module jdb_combine #(
  parameter int DELTA_BITS = jdb_pkg::DELTA_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  input  logic [jdb_pkg::WORD_W-1:0]   up_fw,
  input  logic [jdb_pkg::WORD_W-1:0]   up_gw,
  input  logic signed [DELTA_BITS-1:0] up_delta,
  input  jdb_pkg::jdb_in_t             up_data,
  output logic                         done,
  output jdb_pkg::jdb_out_t            result
);

  localparam int CW = jdb_pkg::COEF_W;
  localparam int PW = jdb_pkg::PROD_W;
  localparam int SH = jdb_pkg::SCALE_SHIFT;
  localparam int NPROD = 12;

  logic [jdb_pkg::WORD_W-1:0] af;
  logic [jdb_pkg::WORD_W-1:0] ag;
  logic signed [CW-1:0]       coef_next [4];

  logic                         e_valid;
  logic signed [CW-1:0]         e_coef [4];
  logic [jdb_pkg::WORD_W-1:0]   e_op [6];
  logic signed [DELTA_BITS-1:0] e_delta;

  logic signed [CW-1:0]       sel_coef [NPROD];
  logic [jdb_pkg::WORD_W-1:0] sel_op [NPROD];

  logic                         p_valid;
  logic signed [54:0]           p_lo [NPROD];
  logic signed [53:0]           p_hi [NPROD];
  logic signed [DELTA_BITS-1:0] p_delta;

  logic                         c_valid;
  logic [PW-1:0]                c_prod [NPROD];
  logic signed [DELTA_BITS-1:0] c_delta;

  logic [PW-1:0]     sum_f;
  logic [PW-1:0]     sum_g;
  logic [15:0]       delta_field;
  jdb_pkg::jdb_out_t result_next;

  // u and r are bits 41..21 of the word plus the half round, v and s the bits above plus bit 41.
  always_comb begin
    af = up_fw + jdb_pkg::HALF_ROUND;
    ag = up_gw + jdb_pkg::HALF_ROUND;
    coef_next[0] = CW'(signed'(af[41:21]));
    coef_next[1] = af[63:42] + CW'(af[41]);
    coef_next[2] = CW'(signed'(ag[41:21]));
    coef_next[3] = ag[63:42] + CW'(ag[41]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      e_coef[k] <= coef_next[k];
    end
    e_op[0] <= up_data.f_in;
    e_op[1] <= up_data.g_in;
    e_op[2] <= up_data.uu_in;
    e_op[3] <= up_data.vv_in;
    e_op[4] <= up_data.rr_in;
    e_op[5] <= up_data.ss_in;
    e_delta <= up_delta;
  end

  // Product order: u*f, v*g, r*f, s*g, u*uu, v*rr, u*vv, v*ss, r*uu, s*rr, r*vv, s*ss.
  always_comb begin
    sel_coef[0] = e_coef[0];   sel_op[0] = e_op[0];
    sel_coef[1] = e_coef[1];   sel_op[1] = e_op[1];
    sel_coef[2] = e_coef[2];   sel_op[2] = e_op[0];
    sel_coef[3] = e_coef[3];   sel_op[3] = e_op[1];
    sel_coef[4] = e_coef[0];   sel_op[4] = e_op[2];
    sel_coef[5] = e_coef[1];   sel_op[5] = e_op[4];
    sel_coef[6] = e_coef[0];   sel_op[6] = e_op[3];
    sel_coef[7] = e_coef[1];   sel_op[7] = e_op[5];
    sel_coef[8] = e_coef[2];   sel_op[8] = e_op[2];
    sel_coef[9] = e_coef[3];   sel_op[9] = e_op[4];
    sel_coef[10] = e_coef[2];  sel_op[10] = e_op[3];
    sel_coef[11] = e_coef[3];  sel_op[11] = e_op[5];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NPROD; k++) begin
      p_lo[k] <= sel_coef[k] * signed'({1'b0, sel_op[k][31:0]});
      p_hi[k] <= sel_coef[k] * signed'(sel_op[k][63:32]);
    end
    p_delta <= e_delta;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NPROD; k++) begin
      c_prod[k] <= {p_hi[k], 32'b0} + {{(PW-55){p_lo[k][54]}}, p_lo[k]};
    end
    c_delta <= p_delta;
  end

  always_comb begin
    sum_f = c_prod[0] + c_prod[1];
    sum_g = c_prod[2] + c_prod[3];
    for (int i = 0; i < 16; i++) begin
      if (i < DELTA_BITS) begin
        delta_field[i] = c_delta[i];
      end else begin
        delta_field[i] = 1'b0;
      end
    end
    result_next.delta_out = delta_field;
    result_next.f_out = sum_f[SH+63:SH];
    result_next.g_out = sum_g[SH+63:SH];
    result_next.uu_out = c_prod[4][63:0] + c_prod[5][63:0];
    result_next.vv_out = c_prod[6][63:0] + c_prod[7][63:0];
    result_next.rr_out = c_prod[8][63:0] + c_prod[9][63:0];
    result_next.ss_out = c_prod[10][63:0] + c_prod[11][63:0];
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      p_valid <= 1'b0;
      c_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      e_valid <= up_valid;
      p_valid <= e_valid;
      c_valid <= p_valid;
      done <= c_valid;
    end
  end

endmodule

@@ rtl/jump_divstep_batch20.sv @@
// Top level of the twenty-step divstep jump block.
// Instantiates the divstep cell chain and the product pipeline; depends on jdb_pkg,
// jdb_step_cell and jdb_combine.
//
// Usage:
//   A beat on operand is taken at a rising edge with start high and busy low.
//   busy is high only while rst is high, so a new beat may enter every cycle.
//   Each beat walks through STEPS_PER_JUMP divstep cells, one register per cell,
//   then through four stages that extract the jump matrix, form the partial
//   products, assemble the full products and add them.
//   The result beat appears on result with done high for exactly one cycle
//   once it has passed the cell registers and the four combine stages.
//   Throughput is one beat per cycle while rst is low.
//   Results come out in the order the beats went in.
//   The receiver cannot stall: a result must be taken in the cycle it is shown.
//   Synchronous reset clears every valid bit in the pipeline, so no done
//   pulse follows reset until a new beat is taken; beats in flight are dropped.
`timescale 1ns / 1ps

module jump_divstep_batch20 #(
  parameter int STEPS_PER_JUMP = jdb_pkg::STEPS_PER_JUMP,
  parameter int DELTA_BITS = jdb_pkg::DELTA_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  jdb_pkg::jdb_in_t  operand,
  output logic              done,
  output jdb_pkg::jdb_out_t result
);

  logic                         chain_valid [STEPS_PER_JUMP+1];
  logic [jdb_pkg::WORD_W-1:0]   chain_fw [STEPS_PER_JUMP+1];
  logic [jdb_pkg::WORD_W-1:0]   chain_gw [STEPS_PER_JUMP+1];
  logic signed [DELTA_BITS-1:0] chain_delta [STEPS_PER_JUMP+1];
  jdb_pkg::jdb_in_t             chain_data [STEPS_PER_JUMP+1];
  logic signed [DELTA_BITS-1:0] delta_start;

  assign busy = rst;

  always_comb begin
    for (int i = 0; i < DELTA_BITS; i++) begin
      if (i < jdb_pkg::DELTA_FIELD_W) begin
        delta_start[i] = operand.delta_in[i];
      end else begin
        delta_start[i] = operand.delta_in[jdb_pkg::DELTA_FIELD_W-1];
      end
    end
  end

  // The packed words are the low twenty bits minus 2^41 and minus 2^62.
  assign chain_valid[0] = start && !busy;
  assign chain_fw[0] = {23'h7F_FFFF, 21'b0, operand.f_in[19:0]};
  assign chain_gw[0] = {2'b11, 42'b0, operand.g_in[19:0]};
  assign chain_delta[0] = delta_start;
  assign chain_data[0] = operand;

  for (genvar c = 0; c < STEPS_PER_JUMP; c++) begin : g_cell
    jdb_step_cell #(
      .DELTA_BITS(DELTA_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[c]),
      .up_fw    (chain_fw[c]),
      .up_gw    (chain_gw[c]),
      .up_delta (chain_delta[c]),
      .up_data  (chain_data[c]),
      .valid    (chain_valid[c+1]),
      .fw       (chain_fw[c+1]),
      .gw       (chain_gw[c+1]),
      .delta    (chain_delta[c+1]),
      .data     (chain_data[c+1])
    );
  end

  jdb_combine #(
    .DELTA_BITS(DELTA_BITS)
  ) u_combine (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[STEPS_PER_JUMP]),
    .up_fw    (chain_fw[STEPS_PER_JUMP]),
    .up_gw    (chain_gw[STEPS_PER_JUMP]),
    .up_delta (chain_delta[STEPS_PER_JUMP]),
    .up_data  (chain_data[STEPS_PER_JUMP]),
    .done     (done),
    .result   (result)
  );

endmodule
